FILE: hdl/trz_pkg.sv
// ----------------------------------------------------------------------------
// trz_pkg: shared constants for the triangle rasterizer with depth buffer
// Command codes, field widths and store values used by the core and the testbench.
// ----------------------------------------------------------------------------
`default_nettype none

package trz_pkg;

   // request commands
   localparam logic CMD_DRAW = 1'b0;
   localparam logic CMD_READ = 1'b1;

   // default screen size
   localparam int SCREEN_WIDTH_DEF  = 64;
   localparam int SCREEN_HEIGHT_DEF = 64;

   // field widths
   localparam int VTX_W   = 16;   // signed Q11.4 vertex coordinate
   localparam int Z_W     = 16;   // depth
   localparam int COLOR_W = 24;   // packed RGB
   localparam int INDEX_W = 12;   // read index
   localparam int COUNT_W = 13;   // pixels written
   localparam int COORD_W = 12;   // whole pixel coordinate, up to 2047

   // depth of an empty pixel and saturation of the write count
   localparam logic [Z_W-1:0]     DEPTH_EMPTY = '1;
   localparam logic [COUNT_W-1:0] COUNT_MAX   = '1;

endpackage

`default_nettype wire

FILE: hdl/trz_ram.sv
// ----------------------------------------------------------------------------
// trz_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module trz_ram #(
   parameter int WIDTH = 40,
   parameter int DEPTH = 4096
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

`default_nettype wire

FILE: hdl/triangle_rasterizer_zbuffer_core.sv
// ----------------------------------------------------------------------------
// triangle_rasterizer_zbuffer_core: edge-function rasterizer with depth buffer
// Draws triangles into a color/depth store and reads single pixels back.
// ----------------------------------------------------------------------------
// After reset the core sweeps the pixel store (busy high) to set every color
// to zero and every depth to empty.
// A request is taken when start is high and busy is low; exactly one
// response follows on rsp_valid for one cycle and cannot be held off. A read
// returns the registered store word. A draw runs a setup, then tests each
// pixel of the clamped bounding box against the triangle and goes on to the
// depth steps only for pixels inside: one shared signed multiplier builds the
// edge values and the depth numerator, a radix-2 divider produces the 16-bit
// depth one bit a cycle, and the store is read and conditionally written once
// per covered pixel.
`default_nettype none

module triangle_rasterizer_zbuffer_core #(
   parameter int SCREEN_WIDTH  = trz_pkg::SCREEN_WIDTH_DEF,
   parameter int SCREEN_HEIGHT = trz_pkg::SCREEN_HEIGHT_DEF
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                start,
   output logic                                     busy,
   input  wire logic                                req_command,
   input  wire logic signed [trz_pkg::VTX_W-1:0]    req_ax,
   input  wire logic signed [trz_pkg::VTX_W-1:0]    req_ay,
   input  wire logic signed [trz_pkg::VTX_W-1:0]    req_bx,
   input  wire logic signed [trz_pkg::VTX_W-1:0]    req_by,
   input  wire logic signed [trz_pkg::VTX_W-1:0]    req_cx,
   input  wire logic signed [trz_pkg::VTX_W-1:0]    req_cy,
   input  wire logic        [trz_pkg::Z_W-1:0]      req_za,
   input  wire logic        [trz_pkg::Z_W-1:0]      req_zb,
   input  wire logic        [trz_pkg::Z_W-1:0]      req_zc,
   input  wire logic        [trz_pkg::COLOR_W-1:0]  req_fill_color,
   input  wire logic        [trz_pkg::INDEX_W-1:0]  req_read_index,
   output logic                                     rsp_valid,
   output logic             [trz_pkg::COLOR_W-1:0]  rsp_pixel_color,
   output logic             [trz_pkg::Z_W-1:0]      rsp_pixel_depth,
   output logic             [trz_pkg::COUNT_W-1:0]  rsp_pixels_written
);

   import trz_pkg::*;

   localparam int PIXELS = SCREEN_WIDTH * SCREEN_HEIGHT;
   localparam int ADDR_W = $clog2(PIXELS);
   localparam int MEM_W  = COLOR_W + Z_W;
   localparam int W_W    = 40;           // edge value
   localparam int AREA_W = W_W + 2;      // sum of three magnitudes
   localparam int NUM_W  = 56;           // depth numerator
   localparam int DIV_W  = 58;           // divider remainder and divisor
   localparam int OPA_W  = 41;
   localparam int OPB_W  = 18;
   localparam int MUL_W  = OPA_W + OPB_W;
   localparam logic signed [COORD_W:0] X_MAX = (COORD_W+1)'(SCREEN_WIDTH - 1);
   localparam logic signed [COORD_W:0] Y_MAX = (COORD_W+1)'(SCREEN_HEIGHT - 1);
   localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(PIXELS - 1);
   localparam logic [ADDR_W-1:0] ROW_STEP  = ADDR_W'(SCREEN_WIDTH);

   typedef enum logic [3:0] {
      ST_CLEAR, ST_IDLE, ST_BOX, ST_SETUP, ST_TEST,
      ST_DEPTH, ST_DIV, ST_LOOK, ST_CMP, ST_RDATA
   } state_type;

   state_type state_ff, state_in;
   logic [4:0] step_ff, step_in;
   logic [ADDR_W-1:0] clr_ff, clr_in;

   logic signed [VTX_W-1:0] vx_ff [3], vx_in [3];
   logic signed [VTX_W-1:0] vy_ff [3], vy_in [3];
   logic [Z_W-1:0] z_ff [3], z_in [3];
   logic [COLOR_W-1:0] color_ff, color_in;
   logic rd_oob_ff, rd_oob_in;

   logic [COORD_W-1:0] x0_ff, x0_in, x1_ff, x1_in, y1_ff, y1_in;
   logic [COORD_W-1:0] x_ff, x_in, y_ff, y_in;
   logic [ADDR_W-1:0] addr_ff, addr_in, row_addr_ff, row_addr_in;

   logic signed [VTX_W:0] dx_ff [3], dx_in [3], dy_ff [3], dy_in [3];
   logic signed [W_W-1:0] w_ff [3], w_in [3], wrow_ff [3], wrow_in [3];
   logic [W_W-1:0] mag_ff [3], mag_in [3];
   logic [AREA_W-1:0] area_ff, area_in;
   logic signed [MUL_W-1:0] mul_ff, mul_in;
   logic [NUM_W-1:0] num_ff, num_in;
   logic [DIV_W-1:0] rem_ff, rem_in, div_ff, div_in;
   logic [Z_W-1:0] q_ff, q_in;
   logic [COUNT_W-1:0] count_ff, count_in;

   logic rsp_valid_ff, rsp_valid_in;
   logic [COLOR_W-1:0] rsp_color_ff, rsp_color_in;
   logic [Z_W-1:0] rsp_depth_ff, rsp_depth_in;
   logic [COUNT_W-1:0] rsp_count_ff, rsp_count_in;

   // shared multiplier operands
   logic signed [OPA_W-1:0] op_a;
   logic signed [OPB_W-1:0] op_b;

   // store port
   logic ram_we;
   logic [ADDR_W-1:0] ram_waddr, ram_raddr;
   logic [MEM_W-1:0] ram_wdata, ram_rdata;

   function automatic logic signed [VTX_W-1:0] min3(
      input logic signed [VTX_W-1:0] a, input logic signed [VTX_W-1:0] b,
      input logic signed [VTX_W-1:0] c);
      logic signed [VTX_W-1:0] m;
      m = (a < b) ? a : b;
      return (m < c) ? m : c;
   endfunction

   function automatic logic signed [VTX_W-1:0] max3(
      input logic signed [VTX_W-1:0] a, input logic signed [VTX_W-1:0] b,
      input logic signed [VTX_W-1:0] c);
      logic signed [VTX_W-1:0] m;
      m = (a > b) ? a : b;
      return (m > c) ? m : c;
   endfunction

   trz_ram #(.WIDTH(MEM_W), .DEPTH(PIXELS)) u_store (
      .clock  (clock),
      .wr_en  (ram_we),
      .wr_addr(ram_waddr),
      .wr_data(ram_wdata),
      .rd_addr(ram_raddr),
      .rd_data(ram_rdata)
   );

   // one shared signed multiplier, registered
   assign mul_in = MUL_W'(op_a) * MUL_W'(op_b);

   always_comb begin
      logic signed [VTX_W-1:0] mnx, mxx, mny, mxy;
      logic signed [COORD_W:0] fx0, fx1, fy0, fy1, lo_x, hi_x, lo_y, hi_y;
      logic [INDEX_W+ADDR_W-1:0] idx_wide;
      logic signed [OPB_W-1:0] px_ref, py_ref;
      logic signed [OPB_W-1:0] dpx, dpy;
      logic [2:0] pi, qi;
      logic [2:0] sel;
      logic [1:0] ek;
      logic signed [W_W-1:0] stepx [3], stepy [3];
      logic [AREA_W-1:0] area_sum;
      logic pos, neg, ge, last_x;
      logic [ADDR_W-1:0] row_next;

      state_in     = state_ff;
      step_in      = step_ff;
      clr_in       = clr_ff;
      vx_in        = vx_ff;
      vy_in        = vy_ff;
      z_in         = z_ff;
      color_in     = color_ff;
      rd_oob_in    = rd_oob_ff;
      x0_in        = x0_ff;
      x1_in        = x1_ff;
      y1_in        = y1_ff;
      x_in         = x_ff;
      y_in         = y_ff;
      addr_in      = addr_ff;
      row_addr_in  = row_addr_ff;
      dx_in        = dx_ff;
      dy_in        = dy_ff;
      w_in         = w_ff;
      wrow_in      = wrow_ff;
      mag_in       = mag_ff;
      area_in      = area_ff;
      num_in       = num_ff;
      rem_in       = rem_ff;
      div_in       = div_ff;
      q_in         = q_ff;
      count_in     = count_ff;
      rsp_valid_in = 1'b0;
      rsp_color_in = rsp_color_ff;
      rsp_depth_in = rsp_depth_ff;
      rsp_count_in = rsp_count_ff;
      op_a         = '0;
      op_b         = '0;
      ram_we       = 1'b0;
      ram_waddr    = addr_ff;
      ram_wdata    = {color_ff, q_ff};
      ram_raddr    = addr_ff;

      // bounding box, floored and clamped to the screen
      mnx  = min3(vx_ff[0], vx_ff[1], vx_ff[2]);
      mxx  = max3(vx_ff[0], vx_ff[1], vx_ff[2]);
      mny  = min3(vy_ff[0], vy_ff[1], vy_ff[2]);
      mxy  = max3(vy_ff[0], vy_ff[1], vy_ff[2]);
      fx0  = {mnx[VTX_W-1], mnx[VTX_W-1:4]};
      fx1  = {mxx[VTX_W-1], mxx[VTX_W-1:4]};
      fy0  = {mny[VTX_W-1], mny[VTX_W-1:4]};
      fy1  = {mxy[VTX_W-1], mxy[VTX_W-1:4]};
      lo_x = fx0[COORD_W] ? '0 : fx0;
      lo_y = fy0[COORD_W] ? '0 : fy0;
      hi_x = (fx1 > X_MAX) ? X_MAX : fx1;
      hi_y = (fy1 > Y_MAX) ? Y_MAX : fy1;

      idx_wide = (INDEX_W+ADDR_W)'(req_read_index);

      // pixel center of the current box corner
      px_ref = {2'b00, x0_ff, 4'b1000};
      py_ref = {2'b00, y_ff, 4'b1000};
      dpx    = '0;
      dpy    = '0;

      // per-pixel edge increments
      for (int k = 0; k < 3; k++) begin
         stepx[k] = {{(W_W-VTX_W-5){dy_ff[k][VTX_W]}}, dy_ff[k], 4'b0000};
         stepy[k] = {{(W_W-VTX_W-5){dx_ff[k][VTX_W]}}, dx_ff[k], 4'b0000};
      end

      // inside test and magnitudes
      pos = 1'b1;
      neg = 1'b1;
      area_sum = '0;
      for (int k = 0; k < 3; k++) begin
         mag_in[k] = w_ff[k][W_W-1] ? W_W'(-w_ff[k]) : W_W'(w_ff[k]);
         area_sum  = area_sum + AREA_W'(mag_in[k]);
         if (w_ff[k][W_W-1]) pos = 1'b0;
         if (!w_ff[k][W_W-1] && (w_ff[k] != '0)) neg = 1'b0;
      end

      ge       = rem_ff >= div_ff;
      last_x   = x_ff == x1_ff;
      row_next = row_addr_ff + ROW_STEP;
      sel      = '0;
      ek       = '0;
      pi       = '0;
      qi       = '0;

      case (state_ff)
         // sweep the store after reset
         ST_CLEAR: begin
            ram_we    = 1'b1;
            ram_waddr = clr_ff;
            ram_wdata = {{COLOR_W{1'b0}}, DEPTH_EMPTY};
            clr_in    = clr_ff + 1'b1;
            if (clr_ff == LAST_ADDR) begin
               state_in = ST_IDLE;
            end
         end

         // take a request
         ST_IDLE: begin
            ram_raddr = idx_wide[ADDR_W-1:0];
            if (start) begin
               vx_in     = '{req_ax, req_bx, req_cx};
               vy_in     = '{req_ay, req_by, req_cy};
               z_in      = '{req_za, req_zb, req_zc};
               color_in  = req_fill_color;
               rd_oob_in = idx_wide >= (INDEX_W+ADDR_W)'(PIXELS);
               count_in  = '0;
               state_in  = (req_command == CMD_READ) ? ST_RDATA : ST_BOX;
            end
         end

         ST_RDATA: begin
            rsp_valid_in = 1'b1;
            rsp_color_in = rd_oob_ff ? '0 : ram_rdata[MEM_W-1:Z_W];
            rsp_depth_in = rd_oob_ff ? DEPTH_EMPTY : ram_rdata[Z_W-1:0];
            rsp_count_in = '0;
            state_in     = ST_IDLE;
         end

         // box limits and edge deltas
         ST_BOX: begin
            x0_in       = lo_x[COORD_W-1:0];
            x1_in       = hi_x[COORD_W-1:0];
            x_in        = lo_x[COORD_W-1:0];
            y_in        = lo_y[COORD_W-1:0];
            y1_in       = hi_y[COORD_W-1:0];
            row_addr_in = ADDR_W'(int'(lo_y[COORD_W-1:0]) * SCREEN_WIDTH);
            addr_in     = ADDR_W'(int'(lo_y[COORD_W-1:0]) * SCREEN_WIDTH)
                          + ADDR_W'(lo_x[COORD_W-1:0]);
            for (int k = 0; k < 3; k++) begin
               pi = 3'((k + 1) % 3);
               qi = 3'((k + 2) % 3);
               dx_in[k] = {vx_ff[qi[1:0]][VTX_W-1], vx_ff[qi[1:0]]}
                          - {vx_ff[pi[1:0]][VTX_W-1], vx_ff[pi[1:0]]};
               dy_in[k] = {vy_ff[qi[1:0]][VTX_W-1], vy_ff[qi[1:0]]}
                          - {vy_ff[pi[1:0]][VTX_W-1], vy_ff[pi[1:0]]};
            end
            step_in = '0;
            if ((lo_x > hi_x) || (lo_y > hi_y)) begin
               rsp_valid_in = 1'b1;
               rsp_color_in = '0;
               rsp_depth_in = '0;
               rsp_count_in = '0;
               state_in     = ST_IDLE;
            end else begin
               state_in = ST_SETUP;
            end
         end

         // edge values at the box corner: six products, accumulated
         ST_SETUP: begin
            if (step_ff < 5'd6) begin
               sel = step_ff[2:0];
               ek  = 2'(sel >> 1);
               pi  = (ek == 2'd2) ? 3'd0 : ({1'b0, ek} + 3'd1);
               // signed offsets of the pixel center from the edge start
               dpx = px_ref - {{2{vx_ff[pi[1:0]][VTX_W-1]}}, vx_ff[pi[1:0]]};
               dpy = py_ref - {{2{vy_ff[pi[1:0]][VTX_W-1]}}, vy_ff[pi[1:0]]};
               if (!sel[0]) begin
                  op_a = OPA_W'(dpx);
                  op_b = OPB_W'(dy_ff[ek]);
               end else begin
                  op_a = OPA_W'(dpy);
                  op_b = OPB_W'(dx_ff[ek]);
               end
            end
            if (step_ff != '0) begin
               sel = 3'(step_ff - 5'd1);
               ek  = 2'(sel >> 1);
               if (!sel[0]) begin
                  w_in[ek] = mul_ff[W_W-1:0];
               end else begin
                  w_in[ek] = w_ff[ek] - mul_ff[W_W-1:0];
               end
               wrow_in[ek] = w_in[ek];
            end
            step_in = step_ff + 1'b1;
            if (step_ff == 5'd6) begin
               state_in = ST_TEST;
            end
         end

         // edge test of one pixel
         ST_TEST: begin
            area_in = area_sum;
            if ((pos || neg) && (area_sum != '0)) begin
               num_in   = '0;
               step_in  = '0;
               state_in = ST_DEPTH;
            end else begin
               state_in = ST_TEST;
               if (last_x) begin
                  if (y_ff == y1_ff) begin
                     rsp_valid_in = 1'b1;
                     rsp_color_in = '0;
                     rsp_depth_in = '0;
                     rsp_count_in = count_ff;
                     state_in     = ST_IDLE;
                  end else begin
                     y_in        = y_ff + 1'b1;
                     x_in        = x0_ff;
                     row_addr_in = row_next;
                     addr_in     = row_next + ADDR_W'(x0_ff);
                     for (int k = 0; k < 3; k++) begin
                        wrow_in[k] = wrow_ff[k] - stepy[k];
                        w_in[k]    = wrow_ff[k] - stepy[k];
                     end
                  end
               end else begin
                  x_in    = x_ff + 1'b1;
                  addr_in = addr_ff + 1'b1;
                  for (int k = 0; k < 3; k++) begin
                     w_in[k] = w_ff[k] + stepx[k];
                  end
               end
            end
         end

         // depth numerator: three products, accumulated
         ST_DEPTH: begin
            if (step_ff < 5'd3) begin
               ek   = step_ff[1:0];
               op_a = OPA_W'(mag_ff[ek]);
               op_b = OPB_W'(z_ff[ek]);
            end
            if (step_ff != '0) begin
               num_in = num_ff + mul_ff[NUM_W-1:0];
            end
            step_in = step_ff + 1'b1;
            if (step_ff == 5'd3) begin
               rem_in   = DIV_W'(num_ff + mul_ff[NUM_W-1:0]);
               div_in   = {1'b0, area_ff, 15'b0};
               q_in     = '0;
               step_in  = '0;
               state_in = ST_DIV;
            end
         end

         // restoring division, one quotient bit a cycle
         ST_DIV: begin
            rem_in  = ge ? rem_ff - div_ff : rem_ff;
            q_in    = {q_ff[Z_W-2:0], ge};
            div_in  = div_ff >> 1;
            step_in = step_ff + 1'b1;
            if (step_ff == 5'd15) begin
               state_in = ST_LOOK;
            end
         end

         // read the stored depth
         ST_LOOK: begin
            state_in = ST_CMP;
         end

         // depth compare, write and move on
         ST_CMP: begin
            if (q_ff < ram_rdata[Z_W-1:0]) begin
               ram_we = 1'b1;
               if (count_ff != COUNT_MAX) begin
                  count_in = count_ff + 1'b1;
               end
            end
            state_in = ST_TEST;
            if (last_x) begin
               if (y_ff == y1_ff) begin
                  rsp_valid_in = 1'b1;
                  rsp_color_in = '0;
                  rsp_depth_in = '0;
                  rsp_count_in = count_in;
                  state_in     = ST_IDLE;
               end else begin
                  y_in        = y_ff + 1'b1;
                  x_in        = x0_ff;
                  row_addr_in = row_next;
                  addr_in     = row_next + ADDR_W'(x0_ff);
                  for (int k = 0; k < 3; k++) begin
                     wrow_in[k] = wrow_ff[k] - stepy[k];
                     w_in[k]    = wrow_ff[k] - stepy[k];
                  end
               end
            end else begin
               x_in    = x_ff + 1'b1;
               addr_in = addr_ff + 1'b1;
               for (int k = 0; k < 3; k++) begin
                  w_in[k] = w_ff[k] + stepx[k];
               end
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      vx_ff        <= vx_in;
      vy_ff        <= vy_in;
      z_ff         <= z_in;
      color_ff     <= color_in;
      rd_oob_ff    <= rd_oob_in;
      x0_ff        <= x0_in;
      x1_ff        <= x1_in;
      y1_ff        <= y1_in;
      x_ff         <= x_in;
      y_ff         <= y_in;
      addr_ff      <= addr_in;
      row_addr_ff  <= row_addr_in;
      dx_ff        <= dx_in;
      dy_ff        <= dy_in;
      w_ff         <= w_in;
      wrow_ff      <= wrow_in;
      mag_ff       <= mag_in;
      area_ff      <= area_in;
      mul_ff       <= mul_in;
      num_ff       <= num_in;
      rem_ff       <= rem_in;
      div_ff       <= div_in;
      q_ff         <= q_in;
      count_ff     <= count_in;
      rsp_color_ff <= rsp_color_in;
      rsp_depth_ff <= rsp_depth_in;
      rsp_count_ff <= rsp_count_in;
   end

   assign busy               = state_ff != ST_IDLE;
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_pixel_color    = rsp_color_ff;
   assign rsp_pixel_depth    = rsp_depth_ff;
   assign rsp_pixels_written = rsp_count_ff;

   // responses are never back-to-back
   a_rsp_gap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |=> !rsp_valid_ff)
      else $error("back-to-back responses");

   // the store is written only by the clear sweep or a depth update
   a_write_src: assert property (@(posedge clock) disable iff (reset)
      ram_we |-> (state_ff == ST_CLEAR || state_ff == ST_CMP))
      else $error("store write outside clear or compare");

   // divider remainder stays below twice the shifted divisor
   a_div_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV) |-> (rem_ff < {div_ff[DIV_W-2:0], 1'b0}))
      else $error("divider remainder out of range");

   // a response leaves the core ready for the next request
   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !busy)
      else $error("response while busy");

endmodule

`default_nettype wire

FILE: tb/sv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: triangle rasterizer with depth buffer
// Drives draw and read requests through the start/busy handshake, keeps its
// own color and depth store, predicts each response and checks it field by
// field as it arrives.
// ----------------------------------------------------------------------------

module testbench;
   import trz_pkg::*;

   localparam int SCR_W       = 64;
   localparam int SCR_H       = 64;
   localparam int PIX_TOTAL   = SCR_W * SCR_H;
   localparam int CYCLE_LIMIT = 50_000_000;
   localparam int MAX_REPORTS = 10;

   typedef struct {
      logic                      command;
      logic signed [VTX_W-1:0]   ax, ay, bx, by, cx, cy;
      logic        [Z_W-1:0]     za, zb, zc;
      logic        [COLOR_W-1:0] fill_color;
      logic        [INDEX_W-1:0] read_index;
   } request_type;

   typedef struct {
      logic [COLOR_W-1:0] pixel_color;
      logic [Z_W-1:0]     pixel_depth;
      logic [COUNT_W-1:0] pixels_written;
   } pixel_rsp_type;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      start = 1'b0;
   logic                      busy;
   logic                      req_command = CMD_READ;
   logic signed [VTX_W-1:0]   req_ax = '0, req_ay = '0, req_bx = '0;
   logic signed [VTX_W-1:0]   req_by = '0, req_cx = '0, req_cy = '0;
   logic        [Z_W-1:0]     req_za = '0, req_zb = '0, req_zc = '0;
   logic        [COLOR_W-1:0] req_fill_color = '0;
   logic        [INDEX_W-1:0] req_read_index = '0;
   logic                      rsp_valid;
   logic        [COLOR_W-1:0] rsp_pixel_color;
   logic        [Z_W-1:0]     rsp_pixel_depth;
   logic        [COUNT_W-1:0] rsp_pixels_written;

   // predictor state: frame and depth store
   logic [COLOR_W-1:0] frame_color [PIX_TOTAL];
   logic [Z_W-1:0]     frame_depth [PIX_TOTAL];
   pixel_rsp_type      pending_pixels [$];

   int errors     = 0;
   int cycles     = 0;
   int idle_pct   = 0;
   int last_pixel = 0;

   triangle_rasterizer_zbuffer_core #(
      .SCREEN_WIDTH (SCR_W),
      .SCREEN_HEIGHT(SCR_H)
   ) DUT (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_command(req_command),
      .req_ax(req_ax), .req_ay(req_ay), .req_bx(req_bx), .req_by(req_by),
      .req_cx(req_cx), .req_cy(req_cy),
      .req_za(req_za), .req_zb(req_zb), .req_zc(req_zc),
      .req_fill_color(req_fill_color), .req_read_index(req_read_index),
      .rsp_valid(rsp_valid), .rsp_pixel_color(rsp_pixel_color),
      .rsp_pixel_depth(rsp_pixel_depth), .rsp_pixels_written(rsp_pixels_written)
   );

   // clock, 2 ns period
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // run watchdog
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   function automatic longint signed edge_value(int x0, int y0, int x1, int y1,
                                                int px, int py);
      return longint'(px - x0) * longint'(y1 - y0) - longint'(py - y0) * longint'(x1 - x0);
   endfunction

   function automatic longint unsigned magnitude(longint signed v);
      return (v < 0) ? longint'(-v) : longint'(v);
   endfunction

   // rasterize one request into the local store and return its response
   function automatic pixel_rsp_type rasterize(request_type r);
      pixel_rsp_type res;
      int ax, ay, bx, by, cx, cy, x0, x1, y0, y1, px, py, idx;
      longint signed w0, w1, w2;
      longint unsigned area, num, depth;
      int unsigned count;
      res = '{default: '0};
      if (r.command == CMD_READ) begin
         res.pixel_color = frame_color[r.read_index];
         res.pixel_depth = frame_depth[r.read_index];
         return res;
      end
      ax = r.ax; ay = r.ay; bx = r.bx; by = r.by; cx = r.cx; cy = r.cy;
      // floor to whole pixels, then clamp to the screen
      x0 = (ax < bx ? (ax < cx ? ax : cx) : (bx < cx ? bx : cx)) >>> 4;
      x1 = (ax > bx ? (ax > cx ? ax : cx) : (bx > cx ? bx : cx)) >>> 4;
      y0 = (ay < by ? (ay < cy ? ay : cy) : (by < cy ? by : cy)) >>> 4;
      y1 = (ay > by ? (ay > cy ? ay : cy) : (by > cy ? by : cy)) >>> 4;
      if (x0 < 0) x0 = 0;
      if (y0 < 0) y0 = 0;
      if (x1 > SCR_W - 1) x1 = SCR_W - 1;
      if (y1 > SCR_H - 1) y1 = SCR_H - 1;
      count = 0;
      for (int y = y0; y <= y1; y++) begin
         for (int x = x0; x <= x1; x++) begin
            px = x * 16 + 8;
            py = y * 16 + 8;
            w0 = edge_value(bx, by, cx, cy, px, py);
            w1 = edge_value(cx, cy, ax, ay, px, py);
            w2 = edge_value(ax, ay, bx, by, px, py);
            // either winding; centers on an edge count as inside
            if (!((w0 >= 0 && w1 >= 0 && w2 >= 0) || (w0 <= 0 && w1 <= 0 && w2 <= 0)))
               continue;
            area = magnitude(w0) + magnitude(w1) + magnitude(w2);
            if (area == 0)
               continue;
            num = magnitude(w0) * r.za + magnitude(w1) * r.zb + magnitude(w2) * r.zc;
            depth = num / area;
            idx = y * SCR_W + x;
            if (depth < frame_depth[idx]) begin
               frame_color[idx] = r.fill_color;
               frame_depth[idx] = depth[Z_W-1:0];
               if (count < COUNT_MAX)
                  count++;
            end
         end
      end
      res.pixels_written = count[COUNT_W-1:0];
      return res;
   endfunction

   // send one request, predict at acceptance, then idle per the current phase
   task automatic send_request(request_type r);
      int gap;
      req_command    <= r.command;
      req_ax <= r.ax; req_ay <= r.ay; req_bx <= r.bx;
      req_by <= r.by; req_cx <= r.cx; req_cy <= r.cy;
      req_za <= r.za; req_zb <= r.zb; req_zc <= r.zc;
      req_fill_color <= r.fill_color;
      req_read_index <= r.read_index;
      start          <= 1'b1;
      do @(posedge clock); while (busy);
      pending_pixels.push_back(rasterize(r));
      gap = ($urandom_range(99) < idle_pct) ? $urandom_range(1, 6) : 0;
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // hold off until every response is in
   task automatic drain_responses();
      start <= 1'b0;
      while (pending_pixels.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   function automatic request_type read_req(int idx);
      request_type r;
      r = '{default: '0};
      r.command    = CMD_READ;
      r.ax         = VTX_W'($urandom);
      r.by         = VTX_W'($urandom);
      r.zc         = Z_W'($urandom);
      r.fill_color = COLOR_W'($urandom);
      r.read_index = INDEX_W'(idx);
      return r;
   endfunction

   function automatic request_type draw_req(int ax, int ay, int bx, int by, int cx, int cy,
                                            int za, int zb, int zc, int color);
      request_type r;
      r.command = CMD_DRAW;
      r.ax = VTX_W'(ax); r.ay = VTX_W'(ay); r.bx = VTX_W'(bx);
      r.by = VTX_W'(by); r.cx = VTX_W'(cx); r.cy = VTX_W'(cy);
      r.za = Z_W'(za); r.zb = Z_W'(zb); r.zc = Z_W'(zc);
      r.fill_color = COLOR_W'(color);
      r.read_index = INDEX_W'($urandom);
      return r;
   endfunction

   // small triangle near the screen, random content
   function automatic request_type random_draw();
      int bx0, by0, span;
      request_type r;
      span = $urandom_range(1, 14) * 16;
      bx0 = int'($urandom_range(0, 80 * 16)) - 8 * 16;
      by0 = int'($urandom_range(0, 80 * 16)) - 8 * 16;
      r = draw_req(bx0 + $urandom_range(0, span), by0 + $urandom_range(0, span),
                   bx0 + $urandom_range(0, span), by0 + $urandom_range(0, span),
                   bx0 + $urandom_range(0, span), by0 + $urandom_range(0, span),
                   $urandom, $urandom, $urandom, $urandom);
      last_pixel = ((by0 >>> 4) & 63) * SCR_W + ((bx0 >>> 4) & 63);
      return r;
   endfunction

   // response checker
   always @(posedge clock) begin
      pixel_rsp_type want;
      if (!reset && rsp_valid) begin
         if (pending_pixels.size() == 0) begin
            errors <= errors + 1;
            if (errors < MAX_REPORTS)
               $display("ERROR: unexpected response color=%h depth=%h count=%0d",
                        rsp_pixel_color, rsp_pixel_depth, rsp_pixels_written);
         end else begin
            want = pending_pixels.pop_front();
            if (rsp_pixel_color !== want.pixel_color ||
                rsp_pixel_depth !== want.pixel_depth ||
                rsp_pixels_written !== want.pixels_written) begin
               errors <= errors + 1;
               if (errors < MAX_REPORTS)
                  $display({"ERROR: color exp %h got %h, depth exp %h got %h, ",
                            "count exp %0d got %0d"},
                           want.pixel_color, rsp_pixel_color, want.pixel_depth,
                           rsp_pixel_depth, want.pixels_written, rsp_pixels_written);
            end
         end
      end
   end

   // reads of untouched pixels return the reset values
   task automatic test_reset_state();
      send_request(read_req(0));
      send_request(read_req(PIX_TOTAL - 1));
      send_request(read_req(12'hA5A));
   endtask

   // directed draws: windings, special cases and extremes
   task automatic test_directed_draws();
      // counterclockwise and clockwise versions of one triangle
      send_request(draw_req(16, 16, 160, 24, 40, 150, 100, 200, 300, 24'hFF0000));
      send_request(draw_req(16, 16, 40, 150, 160, 24, 100, 200, 300, 24'h00FF00));
      // nearer copy overwrites
      send_request(draw_req(16, 16, 160, 24, 40, 150, 0, 0, 0, 24'h0000FF));
      send_request(read_req(2 * SCR_W + 3));
      // zero area: collinear and coincident vertices
      send_request(draw_req(0, 0, 320, 320, 640, 640, 1, 1, 1, 24'h123456));
      send_request(draw_req(200, 200, 200, 200, 200, 200, 1, 1, 1, 24'h123456));
      // box entirely off screen
      send_request(draw_req(-800, -800, -300, -700, -600, -200, 0, 0, 0, 24'hABCDEF));
      send_request(draw_req(2000, 2000, 3000, 2100, 2500, 3000, 0, 0, 0, 24'hABCDEF));
      // empty depth never writes
      send_request(draw_req(600, 600, 900, 620, 700, 900, 65535, 65535, 65535, 24'hFFFFFF));
      send_request(read_req(45 * SCR_W + 45));
      // negative fractional coordinates floor below zero
      send_request(draw_req(-9, -9, 70, -3, -5, 80, 40, 50, 60, 24'h00FFFF));
      send_request(read_req(0));
      // whole screen under coordinate extremes
      send_request(draw_req(-32768, -32768, 32767, -32768, -32768, 32767,
                            65535, 0, 0, 24'hFFFFFF));
      send_request(draw_req(32767, 32767, -32768, 32767, 32767, -32768,
                            0, 65535, 65535, 24'h000000));
      send_request(read_req(PIX_TOTAL - 1));
      send_request(read_req(SCR_W * 32 + 5));
      drain_responses();
   endtask

   // random mix: mostly small draws followed by reads into them
   task automatic test_random_mix(int n, int pct);
      request_type r;
      idle_pct = pct;
      for (int i = 0; i < n; i++) begin
         case ($urandom_range(19))
            0:        r = draw_req($urandom, $urandom, $urandom, $urandom,
                                   $urandom, $urandom, $urandom, $urandom,
                                   $urandom, $urandom);
            1, 2, 3:  r = read_req($urandom_range(0, PIX_TOTAL - 1));
            4, 5, 6, 7, 8: r = read_req(last_pixel);
            default:  r = random_draw();
         endcase
         // the full-range noise draw is rare to bound run time
         if (r.command == CMD_DRAW && $urandom_range(3) != 0 && i % 7 == 3)
            r = random_draw();
         send_request(r);
      end
      drain_responses();
   endtask

   initial begin
      for (int i = 0; i < PIX_TOTAL; i++) begin
         frame_color[i] = '0;
         frame_depth[i] = DEPTH_EMPTY;
      end
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      test_reset_state();
      test_directed_draws();
      test_random_mix(35, 0);
      test_random_mix(35, 71);
      test_random_mix(35, 33);
      test_random_mix(15, 0);
      // settle on the tail of the last draw
      repeat (50) @(posedge clock);
      if (errors == 0 && pending_pixels.size() == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule
